>>> rtl/core/rgbh_pkg.sv
// Shared types and constants for the RGB to HSL converter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rgbh_pkg;

  localparam int unsigned ChanW  = 8;    // one color channel
  localparam int unsigned LsumW  = 9;    // max + min
  localparam int unsigned QuoW   = 16;   // quotient bits, one per cell
  localparam int unsigned DivW   = 11;   // divisor, up to 6 * 255
  localparam int unsigned InW    = 24;   // s_axis_tdata width
  localparam int unsigned OutW   = 48;   // m_axis_tdata width

  localparam logic [LsumW-1:0] LsumHalf = 9'd255;
  localparam logic [LsumW-1:0] LsumFull = 9'd510;

  // One long division in flight: partial remainder, dividend bits still to
  // be brought down, quotient bits so far, divisor.
  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [QuoW-1:0] low;
    logic [QuoW-1:0] quo;
    logic [DivW-1:0] dvsr;
  } div_t;

  // Payload handed from cell to cell.
  typedef struct packed {
    div_t             hue;
    div_t             sat;
    logic [LsumW-1:0] lsum;
  } pipe_t;

endpackage

>>> rtl/core/rgb_to_hsl.sv
// Pipeline: front stage plus 16 divider cells, one quotient bit per cell.
// Throughput: one pixel per cycle while the output is not stalled; both
// divisions run side by side down the same chain of cells.
// Each cell holds its own request, so a stalled output lets bubbles close up.
// Reset (rst_ni low, asynchronous) empties every cell; payload is not reset.
// Top level of the RGB to HSL converter; depends on rgbh_pkg, rgbh_front
// and rgbh_div_cell.
`timescale 1ns / 1ps

module rgb_to_hsl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Pixel in
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [rgbh_pkg::InW-1:0]   s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  // HSL out
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [rgbh_pkg::OutW-1:0]  m_axis_tdata    // hue[15:0], saturation[31:16],
                                                     // lightness_sum[40:32], zero[47:41]
);
  import rgbh_pkg::*;

  // Handshake and payload along the chain: index 0 is the front stage output,
  // index QuoW the last cell, which doubles as the output register.
  logic  valid_c [QuoW+1];
  logic  ready_c [QuoW+1];
  pipe_t data_c  [QuoW+1];

  // Front: find max/min, form lightness, load both dividends and divisors.
  rgbh_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .data_o  (data_c[0])
  );

  // Divider chain: each cell brings down one dividend bit of hue and
  // saturation and emits one quotient bit, most significant first.
  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    rgbh_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .data_i  (data_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .data_o  (data_c[i+1])
    );
  end

  // The last cell's register holds the result until the sink takes it.
  assign ready_c[QuoW] = m_axis_tready;
  assign m_axis_tvalid = valid_c[QuoW];
  assign m_axis_tdata  = {{(OutW - 2*QuoW - LsumW){1'b0}},
                          data_c[QuoW].lsum,
                          data_c[QuoW].sat.quo,
                          data_c[QuoW].hue.quo};

endmodule

>>> rtl/core/rgbh_front.sv
// Front stage: max/min search, lightness and setup of both divisions.
// Depends on rgbh_pkg.
`timescale 1ns / 1ps

module rgbh_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [rgbh_pkg::ChanW-1:0]  red_i,
  input  logic [rgbh_pkg::ChanW-1:0]  green_i,
  input  logic [rgbh_pkg::ChanW-1:0]  blue_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output rgbh_pkg::pipe_t             data_o
);
  import rgbh_pkg::*;

  logic [ChanW-1:0] mx, mn, d;
  logic [LsumW-1:0] sum;
  logic [ChanW-1:0] den;
  logic [DivW-1:0]  d_w, d6, n;
  logic [DivW-1:0]  r_w, g_w, b_w;
  logic             grey;
  pipe_t            data_d, data_q;
  logic             valid_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;

    d    = mx - mn;
    grey = (d == '0);
    sum  = {1'b0, mx} + {1'b0, mn};
    if (sum > LsumHalf) begin
      den = ChanW'(LsumFull - sum);
    end else begin
      den = ChanW'(sum);
    end

    d_w = {{(DivW-ChanW){1'b0}}, d};
    r_w = {{(DivW-ChanW){1'b0}}, red_i};
    g_w = {{(DivW-ChanW){1'b0}}, green_i};
    b_w = {{(DivW-ChanW){1'b0}}, blue_i};
    d6  = (d_w << 2) + (d_w << 1);

    // Sextant numerator; red wins ties, then green.
    if (mx == red_i) begin
      n = g_w - b_w + ((green_i < blue_i) ? d6 : '0);
    end else if (mx == green_i) begin
      n = b_w - r_w + (d_w << 1);
    end else begin
      n = r_w - g_w + (d_w << 2);
    end

    // Hue: dividend n * 2^16, so the high part is n and the low bits are zero.
    data_d.hue.rem  = grey ? '0 : n;
    data_d.hue.low  = '0;
    data_d.hue.quo  = '0;
    data_d.hue.dvsr = grey ? DivW'(1) : d6;

    // Saturation: dividend d * 65535 = (d - 1) * 2^16 + (2^16 - d).
    data_d.sat.rem  = grey ? '0 : d_w - DivW'(1);
    data_d.sat.low  = QuoW'(0) - {{(QuoW-ChanW){1'b0}}, d};
    data_d.sat.quo  = '0;
    data_d.sat.dvsr = grey ? DivW'(1) : {{(DivW-ChanW){1'b0}}, den};

    data_d.lsum = sum;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/rgbh_div_cell.sv
// One cell of the divider chain: one restoring step of each division.
// Depends on rgbh_pkg.
`timescale 1ns / 1ps

module rgbh_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  rgbh_pkg::pipe_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rgbh_pkg::pipe_t data_o
);
  import rgbh_pkg::*;

  function automatic div_t div_step(input div_t x);
    logic [DivW:0] trial;
    div_t          y;
    trial  = {x.rem, x.low[QuoW-1]};
    y      = x;
    y.low  = {x.low[QuoW-2:0], 1'b0};
    if (trial >= {1'b0, x.dvsr}) begin
      y.rem = DivW'(trial - {1'b0, x.dvsr});
      y.quo = {x.quo[QuoW-2:0], 1'b1};
    end else begin
      y.rem = trial[DivW-1:0];
      y.quo = {x.quo[QuoW-2:0], 1'b0};
    end
    return y;
  endfunction

  pipe_t data_d, data_q;
  logic  valid_q;

  always_comb begin
    data_d      = data_i;
    data_d.hue  = div_step(data_i.hue);
    data_d.sat  = div_step(data_i.sat);
  end

  // Advance when this cell is empty or its neighbor takes its request.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/rgbh_checker.sv
// Port-level checks on the RGB to HSL converter, bound to its top level.
// Depends on rgbh_pkg and rgb_to_hsl.
`timescale 1ns / 1ps

module rgbh_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [rgbh_pkg::OutW-1:0] m_axis_tdata
);
  import rgbh_pkg::*;

  // Hold a stalled result and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // An empty output stage means the whole chain can advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  // A ready sink never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while sink ready");

  // Padding stays zero and lightness stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutW-1:2*QuoW+LsumW] == '0) &&
                      (m_axis_tdata[2*QuoW+LsumW-1:2*QuoW] <= LsumFull))
    else $error("result padding or lightness out of range");

  // Zero saturation only comes from a grey pixel: zero hue, even lightness.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2*QuoW-1:QuoW] == '0) |->
      (m_axis_tdata[QuoW-1:0] == '0) && !m_axis_tdata[2*QuoW])
    else $error("zero saturation with nonzero hue or odd lightness");

endmodule

bind rgb_to_hsl rgbh_checker u_rgbh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
